// ===== rtl/npcs_pkg.sv =====
`default_nettype none

package npcs_pkg;

	// Widths fixed by the word formats.
	localparam int unsigned COLOR_W = 15;
	localparam int unsigned CHAN_W = 5;
	localparam int unsigned PIX_W = 8;
	localparam int unsigned PAL_IDX_W = 8;
	localparam int unsigned POS_W = 6;
	localparam int unsigned SQ_W = 16;
	localparam int unsigned DIST_W = 18;

	// Operation codes carried in the func field.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	localparam logic [CHAN_W-1:0] CHAN_MASK = 5'h1F;
	localparam logic [PIX_W-1:0] KEY_FULL = 8'd255;
	localparam logic [DIST_W-1:0] DIST_BOUND = 18'd65536;
	localparam logic [PAL_IDX_W-1:0] FIRST_SCANNED = 8'd2;
	localparam logic [PAL_IDX_W-1:0] TRANSPARENT_IDX = 8'd0;
	localparam logic [POS_W-1:0] LAST_POS = 6'd63;

	// Tag that travels alongside a palette read through the compare pipeline.
	typedef struct packed {
		logic valid;
		logic last;
		logic [PAL_IDX_W-1:0] idx;
	} scan_tag_t;

endpackage

`default_nettype wire

// ===== rtl/npcs_req_if.sv =====
`default_nettype none

interface npcs_req_if;
	import npcs_pkg::*;

	logic valid;
	logic ready;
	logic func;
	logic [6:0] pair_index;
	logic [30:0] color_pair;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;
	logic [POS_W-1:0] pixel_number;

	modport source (
		output valid, func, pair_index, color_pair, red, green, blue, pixel_number,
		input ready
	);

	modport sink (
		input valid, func, pair_index, color_pair, red, green, blue, pixel_number,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/npcs_rsp_if.sv =====
`default_nettype none

interface npcs_rsp_if;
	import npcs_pkg::*;

	logic valid;
	logic ready;
	logic [PAL_IDX_W-1:0] palette_index;
	logic [POS_W-1:0] tile_position;
	logic is_transparent;

	modport source (
		output valid, palette_index, tile_position, is_transparent,
		input ready
	);

	modport sink (
		input valid, palette_index, tile_position, is_transparent,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/npcs_ram.sv =====
`default_nettype none

module npcs_ram #(
	parameter int unsigned WIDTH = 15,
	parameter int unsigned DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

// ===== rtl/npcs_dist.sv =====
`default_nettype none

module npcs_dist (
	input wire logic clk,
	input wire logic arst_n,
	input wire npcs_pkg::scan_tag_t tag_s1,
	input wire logic [npcs_pkg::COLOR_W-1:0] entry_s1,
	input wire logic [npcs_pkg::PIX_W-1:0] red,
	input wire logic [npcs_pkg::PIX_W-1:0] green,
	input wire logic [npcs_pkg::PIX_W-1:0] blue,
	output npcs_pkg::scan_tag_t tag_s2,
	output logic [npcs_pkg::DIST_W-1:0] dist_s2
);
	import npcs_pkg::*;

	function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic [PIX_W-1:0] pal_r, pal_g, pal_b;
	logic [PIX_W-1:0] d_r, d_g, d_b;
	logic [SQ_W-1:0] sq_r, sq_g, sq_b;
	logic [SQ_W-1:0] sq_r_s2, sq_g_s2, sq_b_s2;

	// Palette channels are 5 bits wide and are scaled up by eight to match the pixel.
	assign pal_r = {entry_s1[CHAN_W-1:0] & CHAN_MASK, 3'b000};
	assign pal_g = {entry_s1[2*CHAN_W-1:CHAN_W] & CHAN_MASK, 3'b000};
	assign pal_b = {entry_s1[3*CHAN_W-1:2*CHAN_W] & CHAN_MASK, 3'b000};

	assign d_r = abs_diff(pal_r, red);
	assign d_g = abs_diff(pal_g, green);
	assign d_b = abs_diff(pal_b, blue);

	assign sq_r = SQ_W'(d_r) * SQ_W'(d_r);
	assign sq_g = SQ_W'(d_g) * SQ_W'(d_g);
	assign sq_b = SQ_W'(d_b) * SQ_W'(d_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_r_s2 <= sq_r;
		sq_g_s2 <= sq_g;
		sq_b_s2 <= sq_b;
	end

	assign dist_s2 = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
endmodule

`default_nettype wire

// ===== rtl/nearest_palette_color_search.sv =====
`default_nettype none

// Channel | Direction | Words
// --------+-----------+--------------------------------------------------------
// req     | in        | palette pair load (func 0) or pixel to classify (func 1)
// rsp     | out       | palette index and tile slot, one per pixel word
//
// A load word writes one palette entry as it is taken in and the other in state ST_LOAD2.
// A key-colour pixel is taken straight to the finishing state, with no palette reads.
// Any other pixel reads entries 2 to PALETTE_ENTRIES-1 one per cycle from the palette
// memory through its single read port, then waits for the compare pipeline to drain.
// Reset clears the control state only; the palette is undefined until it is loaded.
// A finished result sits in the output register while the next word is taken in; a
// second result waits inside the block until the first has been taken.

module nearest_palette_color_search #(
	parameter int unsigned PALETTE_ENTRIES = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	npcs_req_if.sink req,
	npcs_rsp_if.source rsp
);
	import npcs_pkg::*;

	localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
	localparam logic [PAL_IDX_W:0] P_LIM = (PAL_IDX_W+1)'(PALETTE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD2 = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;

	logic [2:0] state_q;

	logic req_acc;
	logic is_key;
	logic [PAL_IDX_W-1:0] even_idx;

	// Held pixel and load data.
	logic [PIX_W-1:0] red_q, green_q, blue_q;
	logic [POS_W-1:0] pos_q;
	logic [PAL_IDX_W-1:0] ld_idx_q;
	logic [COLOR_W-1:0] ld_color_q;

	// Scan control and best-so-far.
	logic [IDX_W-1:0] rd_idx_q;
	logic scan_last;
	scan_tag_t tag_s1;
	scan_tag_t tag_s2;
	logic [COLOR_W-1:0] entry_s1;
	logic [DIST_W-1:0] dist_s2;
	logic [DIST_W-1:0] best_dist_q;
	logic [PAL_IDX_W-1:0] best_idx_q;
	logic transp_q;

	// Output register.
	logic out_valid_q;
	logic [PAL_IDX_W-1:0] out_index_q;
	logic [POS_W-1:0] out_pos_q;
	logic out_transp_q;
	logic out_free;

	// Palette memory write port.
	logic ram_we;
	logic [PAL_IDX_W-1:0] wr_idx;
	logic [COLOR_W-1:0] wr_color;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc = req.valid && req.ready;
	assign is_key = (req.red == KEY_FULL) && (req.green == '0) && (req.blue == KEY_FULL);
	assign even_idx = {req.pair_index, 1'b0};
	assign scan_last = (rd_idx_q == LAST_IDX);
	assign out_free = !out_valid_q || rsp.ready;

	// The first colour of a pair is written as the word is taken in, the second in the
	// cycle after. An entry beyond the palette is simply not written.
	always_comb begin
		if (state_q == ST_LOAD2) begin
			wr_idx = ld_idx_q;
			wr_color = ld_color_q;
			ram_we = ({1'b0, ld_idx_q} < P_LIM);
		end else begin
			wr_idx = even_idx;
			wr_color = req.color_pair[COLOR_W-1:0];
			ram_we = req_acc && (req.func == FUNC_LOAD) && ({1'b0, even_idx} < P_LIM);
		end
	end

	npcs_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk(clk),
		.we(ram_we),
		.waddr(wr_idx[IDX_W-1:0]),
		.wdata(wr_color),
		.raddr(rd_idx_q),
		.rdata(entry_s1)
	);

	npcs_dist u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.tag_s1(tag_s1),
		.entry_s1(entry_s1),
		.red(red_q),
		.green(green_q),
		.blue(blue_q),
		.tag_s2(tag_s2),
		.dist_s2(dist_s2)
	);

	// Control: sequencing of loads and scans, and the read tag that lines up with
	// the memory's registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_idx_q <= '0;
			tag_s1 <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				tag_s1 <= '{valid: 1'b1, last: scan_last, idx: PAL_IDX_W'(rd_idx_q)};
			end else begin
				tag_s1 <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.func == FUNC_LOAD) begin
							state_q <= ST_LOAD2;
						end else if (is_key) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
							rd_idx_q <= IDX_W'(FIRST_SCANNED);
						end
					end
				end
				ST_LOAD2: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_WAIT;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (tag_s2.valid && tag_s2.last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Data registers: the held pixel, the second colour of a pair, and the running
	// minimum, and the output register data. A strict compare keeps the first entry on a tie.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			red_q <= req.red;
			green_q <= req.green;
			blue_q <= req.blue;
			pos_q <= LAST_POS - req.pixel_number;
			ld_idx_q <= {req.pair_index, 1'b1};
			ld_color_q <= req.color_pair[16 +: COLOR_W];
			best_dist_q <= DIST_BOUND;
			if (is_key) begin
				best_idx_q <= TRANSPARENT_IDX;
				transp_q <= 1'b1;
			end else begin
				best_idx_q <= FIRST_SCANNED;
				transp_q <= 1'b0;
			end
		end else if (tag_s2.valid && (dist_s2 < best_dist_q)) begin
			best_dist_q <= dist_s2;
			best_idx_q <= tag_s2.idx;
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_index_q <= best_idx_q;
			out_pos_q <= pos_q;
			out_transp_q <= transp_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.palette_index = out_index_q;
	assign rsp.tile_position = out_pos_q;
	assign rsp.is_transparent = out_transp_q;

	// A transparent result always carries the key index.
	a_transp_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.is_transparent |-> rsp.palette_index == TRANSPARENT_IDX)
		else $error("transparent result with a nonzero index");

	// An ordinary result names a scanned palette entry.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.is_transparent |->
			(rsp.palette_index >= FIRST_SCANNED) &&
			({1'b0, rsp.palette_index} < P_LIM))
		else $error("result index outside the scanned range");

	// The compare pipeline holds reads only while a scan is in progress.
	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s2.valid |-> (state_q == ST_SCAN) || (state_q == ST_WAIT))
		else $error("palette read in flight outside a scan");

	// A finished pixel reaches the output in the cycle after when the register is free.
	a_fin_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && !out_valid_q |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished result not moved to the output register");
endmodule

`default_nettype wire
